>>> hw/rtl/mesh_vertex_normal_top_macros.svh
// Assertion macros used by the checker file of the vertex normal block.
`ifndef MESH_VERTEX_NORMAL_TOP_MACROS_SVH
`define MESH_VERTEX_NORMAL_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/mvn_pkg.sv
// Package with the widths, codes and control structs of the vertex normal block.
package mvn_pkg;

   localparam int CRD_W  = 16;  // coordinate field width
   localparam int DIF_W  = 17;  // coordinate difference width
   localparam int MUL_W  = 31;  // signed multiplier operand width
   localparam int PRD_W  = 62;  // multiplier product width
   localparam int VEC_W  = 36;  // cross product / magnitude width
   localparam int NORM_W = 30;  // the largest magnitude is normalized to [2^29, 2^30)
   localparam int SQ_W   = 62;  // sum of squares width
   localparam int ROOT_W = 31;  // square root width
   localparam int NUM_W  = 48;  // dividend width
   localparam int QUO_W  = 19;  // quotient width
   localparam int SUM_W  = 24;  // accumulator width
   localparam int OUT_W  = 16;  // output component width
   localparam int FLAT_W = 5;   // flat triangle counter width

   // Coordinates are read as two's complement values of this many bits.
   localparam int COORD_BITS = 16;

   localparam int FRAC_TRI = 16;  // Q2.16 triangle normals
   localparam int FRAC_OUT = 15;  // Q1.15 output normal

   localparam logic signed [SUM_W:0] SUM_HI = (SUM_W + 1)'((1 << (SUM_W - 1)) - 1);
   localparam logic signed [SUM_W:0] SUM_LO = -(SUM_W + 1)'(1 << (SUM_W - 1));
   localparam logic signed [QUO_W:0] OUT_HI = (QUO_W + 1)'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [QUO_W:0] OUT_LO = -(QUO_W + 1)'(1 << (OUT_W - 1));

   // Operand pair selected for the shared multiplier.
   typedef enum logic [3:0] {
      MUL_X_A, MUL_X_B, MUL_Y_A, MUL_Y_B, MUL_Z_A, MUL_Z_B,
      MUL_SQ_X, MUL_SQ_Y, MUL_SQ_Z
   } mul_sel_type;

   // Which neighbor pair forms the current triangle.
   typedef enum logic {
      PAIR_PREV,   // (previous neighbor, current neighbor)
      PAIR_CLOSE   // (current neighbor, first neighbor)
   } pair_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_item;
      pair_type    pair;
      logic        load_diff;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        abs_en;
      logic        abs_sum;
      logic        norm_en;
      logic        sqrt_start;
      logic        div_start;
      logic [1:0]  div_idx;
      logic        frac_out;
      logic        sum_update;
      logic        flat_inc;
      logic        adv_ring;
      logic        first_en;
      logic        out_load;
      logic        clear_ring;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mag_zero;
      logic norm_done;
      logic sqrt_done;
      logic div_done;
   } status_type;

endpackage

>>> hw/rtl/mvn_req_if.sv
// Input item channel: one ring neighbor plus the center vertex.
interface mvn_req_if import mvn_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CRD_W-1:0]   center_x;
   logic [CRD_W-1:0]   center_y;
   logic [CRD_W-1:0]   center_z;
   logic [CRD_W-1:0]   nbr_x;
   logic [CRD_W-1:0]   nbr_y;
   logic [CRD_W-1:0]   nbr_z;
   logic               last_neighbor;

   modport source (output valid, center_x, center_y, center_z, nbr_x, nbr_y, nbr_z,
                   last_neighbor, input ready);
   modport sink (input valid, center_x, center_y, center_z, nbr_x, nbr_y, nbr_z,
                 last_neighbor, output ready);
endinterface

>>> hw/rtl/mvn_rsp_if.sv
// Result item channel: the unit vertex normal and ring statistics.
interface mvn_rsp_if import mvn_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OUT_W-1:0]   normal_x;
   logic [OUT_W-1:0]   normal_y;
   logic [OUT_W-1:0]   normal_z;
   logic [FLAT_W-1:0]  flat_count;
   logic               null_normal;

   modport source (output valid, normal_x, normal_y, normal_z, flat_count, null_normal,
                   input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, flat_count, null_normal,
                 output ready);
endinterface

>>> hw/rtl/mvn_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module mvn_sqrt import mvn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   x,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SQ_W-1:0]   x_ff, x_in;
   logic [SQ_W-1:0]   res_ff, res_in;
   logic [SQ_W-2:0]   bit_ff, bit_in;
   logic [SQ_W-1:0]   trial;

   // One digit step of the restoring square root.
   always_comb begin
      trial   = res_ff + {1'b0, bit_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = x;
         res_in  = '0;
         bit_in  = {1'b1, {(SQ_W - 2){1'b0}}};
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + {1'b0, bit_ff};
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

>>> hw/rtl/mvn_div.sv
// Restoring divider, one quotient bit per cycle; the quotient is known to fit QUO_W bits.
module mvn_div import mvn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [ROOT_W-1:0] den,
   output logic              done,
   output logic [QUO_W-1:0]  quo
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]  nsh_ff, nsh_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [ROOT_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ROOT_W:0]   trial;

   // Shift in one dividend bit and subtract the divisor where it fits.
   always_comb begin
      trial   = {rem_ff[ROOT_W-1:0], nsh_ff[QUO_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      nsh_in  = nsh_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = (ROOT_W + 1)'(num[NUM_W-1:QUO_W]);
         nsh_in  = num[QUO_W-1:0];
         den_in  = den;
         cnt_in  = CNT_W'(QUO_W);
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         nsh_in = nsh_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      nsh_ff <= nsh_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> hw/rtl/mvn_datapath.sv
// Datapath: ring registers, shared multiplier, normalizer, root and divider, accumulator.
module mvn_datapath import mvn_pkg::*; #(
   parameter int MAX_NEIGHBORS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [CRD_W-1:0]  center_x,
   input  logic [CRD_W-1:0]  center_y,
   input  logic [CRD_W-1:0]  center_z,
   input  logic [CRD_W-1:0]  nbr_x,
   input  logic [CRD_W-1:0]  nbr_y,
   input  logic [CRD_W-1:0]  nbr_z,
   output logic [OUT_W-1:0]  normal_x,
   output logic [OUT_W-1:0]  normal_y,
   output logic [OUT_W-1:0]  normal_z,
   output logic [FLAT_W-1:0] flat_count,
   output logic              null_normal
);

   localparam int CW       = (COORD_BITS < CRD_W) ? COORD_BITS : CRD_W;
   localparam int FLAT_CAP = (MAX_NEIGHBORS < 31) ? MAX_NEIGHBORS : 31;
   localparam logic [FLAT_W-1:0] FLAT_MAX = FLAT_W'(FLAT_CAP);

   // Inputs are taken as CW-bit two's complement values.
   function automatic logic signed [CRD_W-1:0] read_coord(input logic [CRD_W-1:0] v);
      logic signed [CW-1:0] t;
      t = v[CW-1:0];
      return CRD_W'(t);
   endfunction

   logic signed [CRD_W-1:0]  c_ff[3], p_ff[3], prev_ff[3], first_ff[3];
   logic signed [CRD_W-1:0]  n1[3], n2[3];
   logic signed [DIF_W-1:0]  d1_ff[3], d2_ff[3];
   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PRD_W-1:0]  prod_in, prod_ff;
   logic                     pv_ff;
   mul_sel_type              psel_ff;
   logic signed [VEC_W-1:0]  b_ff[3];
   logic [SQ_W-1:0]          sq_ff;
   logic signed [VEC_W-1:0]  src[3];
   logic [VEC_W-1:0]         mag_ff[3];
   logic                     neg_ff[3];
   logic                     mag_hi, mag_lo;
   logic [ROOT_W-1:0]        root;
   logic                     sqrt_done;
   logic [NORM_W-1:0]        mag_sel;
   logic [NUM_W-1:0]         num;
   logic                     div_done;
   logic [QUO_W-1:0]         quo;
   logic [1:0]               div_idx_ff;
   logic [QUO_W-1:0]         q_ff[3];
   logic signed [QUO_W:0]    uq[3];
   logic signed [SUM_W:0]    snext[3];
   logic signed [SUM_W-1:0]  sum_ff[3];
   logic [FLAT_W-1:0]        flat_ff;
   logic [OUT_W-1:0]         out_ff[3];
   logic [FLAT_W-1:0]        out_flat_ff;
   logic                     out_null_ff;

   // Pair selection for the triangle being formed.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1[i] = (cmd.pair == PAIR_PREV) ? prev_ff[i] : p_ff[i];
         n2[i] = (cmd.pair == PAIR_PREV) ? p_ff[i] : first_ff[i];
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (cmd.mul_sel)
         MUL_X_A:  begin op_a = MUL_W'(d1_ff[1]); op_b = MUL_W'(d2_ff[2]); end
         MUL_X_B:  begin op_a = MUL_W'(d1_ff[2]); op_b = MUL_W'(d2_ff[1]); end
         MUL_Y_A:  begin op_a = MUL_W'(d1_ff[2]); op_b = MUL_W'(d2_ff[0]); end
         MUL_Y_B:  begin op_a = MUL_W'(d1_ff[0]); op_b = MUL_W'(d2_ff[2]); end
         MUL_Z_A:  begin op_a = MUL_W'(d1_ff[0]); op_b = MUL_W'(d2_ff[1]); end
         MUL_Z_B:  begin op_a = MUL_W'(d1_ff[1]); op_b = MUL_W'(d2_ff[0]); end
         MUL_SQ_X: begin
            op_a = $signed({1'b0, mag_ff[0][NORM_W-1:0]});
            op_b = $signed({1'b0, mag_ff[0][NORM_W-1:0]});
         end
         MUL_SQ_Y: begin
            op_a = $signed({1'b0, mag_ff[1][NORM_W-1:0]});
            op_b = $signed({1'b0, mag_ff[1][NORM_W-1:0]});
         end
         MUL_SQ_Z: begin
            op_a = $signed({1'b0, mag_ff[2][NORM_W-1:0]});
            op_b = $signed({1'b0, mag_ff[2][NORM_W-1:0]});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      prod_in = op_a * op_b;
   end

   // Magnitude source and normalization flags.
   always_comb begin
      mag_hi = 1'b0;
      mag_lo = 1'b1;
      for (int i = 0; i < 3; i++) begin
         src[i] = cmd.abs_sum ? VEC_W'(sum_ff[i]) : b_ff[i];
         mag_hi = mag_hi | (|mag_ff[i][VEC_W-1:NORM_W]);
         mag_lo = mag_lo & ~(|mag_ff[i][VEC_W-1:NORM_W-1]);
      end
   end

   assign status.mag_zero  = (mag_ff[0] == '0) && (mag_ff[1] == '0) && (mag_ff[2] == '0);
   assign status.norm_done = ~mag_hi & ~mag_lo;
   assign status.sqrt_done = sqrt_done;
   assign status.div_done  = div_done;

   // Dividend: scaled magnitude plus half the length, for rounding.
   always_comb begin
      mag_sel = mag_ff[cmd.div_idx][NORM_W-1:0];
      if (cmd.frac_out) begin
         num = (NUM_W'(mag_sel) << FRAC_OUT) + NUM_W'(root >> 1);
      end else begin
         num = (NUM_W'(mag_sel) << FRAC_TRI) + NUM_W'(root >> 1);
      end
   end

   // Signed unit components and the saturating accumulator update.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         uq[i] = neg_ff[i] ? -$signed({1'b0, q_ff[i]}) : $signed({1'b0, q_ff[i]});
         snext[i] = (SUM_W + 1)'(sum_ff[i]) - (SUM_W + 1)'(uq[i]);
      end
   end

   mvn_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .x     (sq_ff),
      .done  (sqrt_done),
      .root  (root)
   );

   mvn_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num),
      .den   (root),
      .done  (div_done),
      .quo   (quo)
   );

   // Ring state: accumulator and flat counter.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_ring) begin
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
         flat_ff <= '0;
      end else begin
         if (cmd.sum_update) begin
            for (int i = 0; i < 3; i++) begin
               if (snext[i] > SUM_HI) sum_ff[i] <= SUM_HI[SUM_W-1:0];
               else if (snext[i] < SUM_LO) sum_ff[i] <= SUM_LO[SUM_W-1:0];
               else sum_ff[i] <= snext[i][SUM_W-1:0];
            end
         end
         if (cmd.flat_inc && (flat_ff < FLAT_MAX)) begin
            flat_ff <= flat_ff + 1'b1;
         end
      end
   end

   // Ring neighbor registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            prev_ff[i]  <= '0;
            first_ff[i] <= '0;
         end
      end else if (cmd.adv_ring) begin
         for (int i = 0; i < 3; i++) begin
            prev_ff[i] <= p_ff[i];
            if (cmd.first_en) first_ff[i] <= p_ff[i];
         end
      end
   end

   // Multiplier pipeline valid.
   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else pv_ff <= cmd.mul_en;
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         c_ff[0] <= read_coord(center_x);
         c_ff[1] <= read_coord(center_y);
         c_ff[2] <= read_coord(center_z);
         p_ff[0] <= read_coord(nbr_x);
         p_ff[1] <= read_coord(nbr_y);
         p_ff[2] <= read_coord(nbr_z);
      end
      if (cmd.load_diff) begin
         for (int i = 0; i < 3; i++) begin
            d1_ff[i] <= DIF_W'(n2[i]) - DIF_W'(n1[i]);
            d2_ff[i] <= DIF_W'(n1[i]) - DIF_W'(c_ff[i]);
         end
      end
      prod_ff <= prod_in;
      psel_ff <= cmd.mul_sel;
      if (pv_ff) begin
         unique case (psel_ff)
            MUL_X_A:  b_ff[0] <= $signed(prod_ff[VEC_W-1:0]);
            MUL_X_B:  b_ff[0] <= b_ff[0] - $signed(prod_ff[VEC_W-1:0]);
            MUL_Y_A:  b_ff[1] <= $signed(prod_ff[VEC_W-1:0]);
            MUL_Y_B:  b_ff[1] <= b_ff[1] - $signed(prod_ff[VEC_W-1:0]);
            MUL_Z_A:  b_ff[2] <= $signed(prod_ff[VEC_W-1:0]);
            MUL_Z_B:  b_ff[2] <= b_ff[2] - $signed(prod_ff[VEC_W-1:0]);
            MUL_SQ_X: sq_ff <= prod_ff;
            MUL_SQ_Y: sq_ff <= sq_ff + prod_ff;
            MUL_SQ_Z: sq_ff <= sq_ff + prod_ff;
            default:  sq_ff <= sq_ff;
         endcase
      end
      if (cmd.abs_en) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= src[i][VEC_W-1];
            mag_ff[i] <= src[i][VEC_W-1] ? VEC_W'(-src[i]) : VEC_W'(src[i]);
         end
      end else if (cmd.norm_en) begin
         for (int i = 0; i < 3; i++) begin
            if (mag_hi) mag_ff[i] <= mag_ff[i] >> 1;
            else if (mag_lo) mag_ff[i] <= mag_ff[i] << 1;
         end
      end
      if (cmd.div_start) div_idx_ff <= cmd.div_idx;
      if (div_done) q_ff[div_idx_ff] <= quo;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_flat_ff <= flat_ff;
         out_null_ff <= status.mag_zero;
         if (status.mag_zero) begin
            out_ff[0] <= OUT_HI[OUT_W-1:0];
            out_ff[1] <= '0;
            out_ff[2] <= '0;
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (uq[i] > OUT_HI) out_ff[i] <= OUT_HI[OUT_W-1:0];
               else if (uq[i] < OUT_LO) out_ff[i] <= OUT_LO[OUT_W-1:0];
               else out_ff[i] <= uq[i][OUT_W-1:0];
            end
         end
      end
   end

   assign normal_x    = out_ff[0];
   assign normal_y    = out_ff[1];
   assign normal_z    = out_ff[2];
   assign flat_count  = out_flat_ff;
   assign null_normal = out_null_ff;

endmodule

>>> hw/rtl/mvn_ctrl.sv
// Controller: sequences cross product, normalization, root and divisions per triangle; the sum skips the cross product.
module mvn_ctrl import mvn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DIFF, S_MUL, S_MUL_DRAIN, S_ABS, S_NORM, S_SQ, S_SQ_DRAIN,
      S_SQRT, S_SQRT_WAIT, S_DIV, S_DIV_WAIT, S_COMMIT, S_TRI_END, S_ADV, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  idx_ff, idx_in;
   pair_type    pair_ff, pair_in;
   logic        sum_phase_ff, sum_phase_in;
   logic        started_ff, started_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pair_in      = pair_ff;
      sum_phase_in = sum_phase_ff;
      started_in   = started_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.pair     = pair_ff;
      cmd.abs_sum  = sum_phase_ff;
      cmd.frac_out = sum_phase_ff;
      cmd.div_idx  = idx_ff[1:0];
      cmd.mul_sel  = MUL_X_A;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               last_in       = req_last;
               pair_in       = PAIR_PREV;
               state_in      = started_ff ? S_DIFF : S_ADV;
            end
         end
         S_DIFF: begin
            cmd.load_diff = 1'b1;
            idx_in        = '0;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            unique case (idx_ff)
               3'd0:    cmd.mul_sel = MUL_X_A;
               3'd1:    cmd.mul_sel = MUL_X_B;
               3'd2:    cmd.mul_sel = MUL_Y_A;
               3'd3:    cmd.mul_sel = MUL_Y_B;
               3'd4:    cmd.mul_sel = MUL_Z_A;
               default: cmd.mul_sel = MUL_Z_B;
            endcase
            idx_in = idx_ff + 1'b1;
            if (idx_ff == 3'd5) state_in = S_MUL_DRAIN;
         end
         S_MUL_DRAIN: state_in = S_ABS;
         S_ABS: begin
            cmd.abs_en = 1'b1;
            state_in   = S_NORM;
         end
         S_NORM: begin
            if (status.mag_zero) begin
               if (sum_phase_ff) begin
                  state_in = S_OUT;
               end else begin
                  cmd.flat_inc = 1'b1;
                  state_in     = S_TRI_END;
               end
            end else if (status.norm_done) begin
               idx_in   = '0;
               state_in = S_SQ;
            end else begin
               cmd.norm_en = 1'b1;
            end
         end
         S_SQ: begin
            cmd.mul_en = 1'b1;
            unique case (idx_ff)
               3'd0:    cmd.mul_sel = MUL_SQ_X;
               3'd1:    cmd.mul_sel = MUL_SQ_Y;
               default: cmd.mul_sel = MUL_SQ_Z;
            endcase
            idx_in = idx_ff + 1'b1;
            if (idx_ff == 3'd2) state_in = S_SQ_DRAIN;
         end
         S_SQ_DRAIN: state_in = S_SQRT;
         S_SQRT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (status.sqrt_done) begin
               idx_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff == 3'd2) ? S_COMMIT : S_DIV;
            end
         end
         S_COMMIT: begin
            if (sum_phase_ff) begin
               state_in = S_OUT;
            end else begin
               cmd.sum_update = 1'b1;
               state_in       = S_TRI_END;
            end
         end
         S_TRI_END: begin
            if (pair_ff == PAIR_PREV) begin
               state_in = S_ADV;
            end else begin
               sum_phase_in = 1'b1;
               state_in     = S_ABS;
            end
         end
         S_ADV: begin
            cmd.adv_ring  = 1'b1;
            cmd.first_en  = !started_ff;
            started_in    = 1'b1;
            if (last_ff) begin
               pair_in  = PAIR_CLOSE;
               state_in = S_DIFF;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff) begin
               cmd.out_load   = 1'b1;
               cmd.clear_ring = 1'b1;
               rsp_valid_in   = 1'b1;
               started_in     = 1'b0;
               sum_phase_in   = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         pair_ff      <= PAIR_PREV;
         sum_phase_ff <= 1'b0;
         started_ff   <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pair_ff      <= pair_in;
         sum_phase_ff <= sum_phase_in;
         started_ff   <= started_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/mesh_vertex_normal_top.sv
// Top level of the mesh vertex normal block.
// Neighbors of one vertex arrive one item at a time in ring order, each with the center
// vertex; the item flagged last_neighbor closes the ring and produces one result, the Q1.15
// unit normal (negated sum of the Q2.16 unit normals of the ring's triangles), the count
// of flat triangles skipped and a flag for a zero sum, which gives (32767,0,0). Items are
// processed one at a time. A first neighbor is only stored in the ring registers; every other
// item forms one triangle, whose time grows with n (up to 29), the number of one-bit
// normalizing shifts; the square root and the three divisions on one shared divider
// dominate. A flat triangle stops after the normalizer check. The last item adds the
// closing triangle and the normalization of the sum. A finished result waits in the
// output register while the next items of the following ring are taken.
module mesh_vertex_normal_top import mvn_pkg::*; #(
   parameter int MAX_NEIGHBORS = 16
) (
   input logic        clock,
   input logic        reset,
   mvn_req_if.sink    req_ch,
   mvn_rsp_if.source  rsp_ch
);

   cmd_type    cmd;
   status_type status;

   mvn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_neighbor),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mvn_datapath #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .center_x    (req_ch.center_x),
      .center_y    (req_ch.center_y),
      .center_z    (req_ch.center_z),
      .nbr_x       (req_ch.nbr_x),
      .nbr_y       (req_ch.nbr_y),
      .nbr_z       (req_ch.nbr_z),
      .normal_x    (rsp_ch.normal_x),
      .normal_y    (rsp_ch.normal_y),
      .normal_z    (rsp_ch.normal_z),
      .flat_count  (rsp_ch.flat_count),
      .null_normal (rsp_ch.null_normal)
   );

endmodule

>>> hw/rtl/mvn_checker.sv
// Port-level checker for the vertex normal block and its bind to the top level.
`include "mesh_vertex_normal_top_macros.svh"

module mvn_checker import mvn_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [OUT_W-1:0]  normal_x,
   input logic [OUT_W-1:0]  normal_y,
   input logic [OUT_W-1:0]  normal_z,
   input logic              null_normal
);

   // A stalled result stays offered.
   `MVN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // Reset leaves no result pending.
   `MVN_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid, "result offered after reset")

   // A null normal is reported as the x axis.
   `MVN_ASSERT_SAME(a_null_axis, clock, reset, rsp_valid && null_normal, (normal_x == 16'h7fff) && (normal_y == '0) && (normal_z == '0), "null normal is not the x axis")

   // A regular normal is never the zero vector.
   `MVN_ASSERT_SAME(a_unit_nonzero, clock, reset, rsp_valid && !null_normal, (normal_x != '0) || (normal_y != '0) || (normal_z != '0), "zero normal without null flag")

endmodule

bind mesh_vertex_normal_top mvn_checker u_mvn_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .normal_x    (rsp_ch.normal_x),
   .normal_y    (rsp_ch.normal_y),
   .normal_z    (rsp_ch.normal_z),
   .null_normal (rsp_ch.null_normal)
);
